@@ rtl/core/dmrb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrb_pkg
// Shared constants, types and helpers of the delimited message ring buffer.
// ----------------------------------------------------------------------------
package dmrb_pkg;

  localparam int DEPTH   = 64;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FIELD_W = 7;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_SEMI       = 8'd59;
  localparam logic [CHAR_W-1:0] CH_BANG       = 8'd33;
  localparam logic [CHAR_W-1:0] CH_PRINT_LOW  = 8'd34;
  localparam logic [CHAR_W-1:0] CH_PRINT_END  = 8'd127;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_out;
    logic               char_valid;
    logic               last;
    logic [FIELD_W-1:0] free_space;
    logic [FIELD_W-1:0] pending_messages;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  // Free slots: DEPTH minus the write-to-read distance modulo DEPTH.
  function automatic logic [FIELD_W-1:0] free_of(input logic [PTR_W-1:0] w,
                                                 input logic [PTR_W-1:0] r);
    logic [CNT_W-1:0] d;
    if (w >= r) begin
      d = CNT_W'(w) - CNT_W'(r);
    end else begin
      d = CNT_W'(w) + CNT_W'(DEPTH) - CNT_W'(r);
    end
    return FIELD_W'(DEPTH) - FIELD_W'(d);
  endfunction

endpackage

@@ rtl/core/delimited_message_ring_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_message_ring_buffer
// Byte ring that collects semicolon-terminated messages and hands them out.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+--------------------------------
// s_axis   | in  | s_axis_tvalid/tready    | tdata: char_in; tuser: opcode
// m_axis   | out | m_axis_tvalid/tready    | tdata: char_out, free_space,
//          |     |                         | pending_messages; tuser:
//          |     |                         | char_valid; tlast: last
//
// A put request or a take request that finds no message gives one result.
// A take of a message first lets the single read port of the store scan
// forward to the delimiter (one read per cycle) so that the free space
// after the take is known, then reads the bytes again to stream them; an
// empty message goes straight to its closing ';'.
// After reset the block writes ';' to entry 0 in its INIT state and accepts
// nothing in that state. A stalled consumer stops the stream; the two-entry
// result buffer lets the block take a new request while a result waits.
//
module delimited_message_ring_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] char_out, [14:8] free_space,
                                      // [21:15] pending_messages, [23:22] zero
  output logic        m_axis_tuser,   // [0] char_valid
  output logic        m_axis_tlast    // last
);
  import dmrb_pkg::*;

  // Sequencer states: INIT seeds entry 0, SCAN finds the end of the oldest
  // message, STREAM sends its bytes, TERM sends the closing ';'.
  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_STREAM = 5'b01000,
    ST_TERM   = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [PTR_W-1:0]  wp, wp_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [PTR_W-1:0]  sp, sp_next;          // stream pointer
  logic [PTR_W-1:0]  scan_ptr, scan_ptr_next;
  logic [PTR_W-1:0]  scan_cnt, scan_cnt_next;
  logic [PTR_W-1:0]  left, left_next;      // bytes still to stream
  logic              dv, dv_next;          // read data is valid for sp

  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  logic              push;
  logic              push_ready;
  result_t           push_data;
  result_t           out_data;

  logic              accept;
  op_t               op;
  logic [CHAR_W-1:0] ch;

  assign op            = op_t'(s_axis_tuser);
  assign ch            = s_axis_tdata;
  assign s_axis_tready = (state == ST_IDLE) && push_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    rp_next       = rp;
    count_next    = count;
    sp_next       = sp;
    scan_ptr_next = scan_ptr;
    scan_cnt_next = scan_cnt;
    left_next     = left;
    dv_next       = dv;
    mem_we        = 1'b0;
    mem_waddr     = wp;
    mem_wdata     = ch;
    mem_re        = 1'b0;
    mem_raddr     = rp;
    push          = 1'b0;
    push_data     = '0;

    unique case (state)
      ST_INIT: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = CH_SEMI;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_TAKE) begin
            if (count != '0) begin
              // Start the scan at the read pointer; data arrives next cycle.
              mem_re        = 1'b1;
              mem_raddr     = rp;
              sp_next       = rp;
              scan_ptr_next = rp;
              scan_cnt_next = '0;
              state_next    = ST_SCAN;
            end else begin
              push                       = 1'b1;
              push_data.last             = 1'b1;
              push_data.free_space       = free_of(wp, rp);
              push_data.pending_messages = FIELD_W'(count);
            end
          end else begin
            if (ch == CH_BANG) begin
              // Clear: reseed entry 0 and rewind both pointers.
              mem_we     = 1'b1;
              mem_waddr  = '0;
              mem_wdata  = CH_SEMI;
              wp_next    = PTR_W'(1);
              rp_next    = PTR_W'(1);
              count_next = '0;
            end else if (ch >= CH_PRINT_LOW && ch < CH_PRINT_END) begin
              mem_we    = 1'b1;
              mem_waddr = wp;
              mem_wdata = ch;
              wp_next   = ptr_next(wp);
              if (ch == CH_SEMI && count < CNT_W'(DEPTH)) begin
                count_next = count + 1'b1;
              end
            end
            push                       = 1'b1;
            push_data.last             = 1'b1;
            push_data.free_space       = free_of(wp_next, rp_next);
            push_data.pending_messages = FIELD_W'(count_next);
          end
        end
      end
      ST_SCAN: begin
        // mem_rdata holds the byte at scan_ptr; fetch the following one.
        mem_re    = 1'b1;
        mem_raddr = ptr_next(scan_ptr);
        if (mem_rdata == CH_SEMI || scan_cnt == PTR_W'(DEPTH - 1)) begin
          rp_next    = ptr_next(scan_ptr);
          count_next = count - 1'b1;
          left_next  = scan_cnt;
          dv_next    = 1'b0;
          state_next = (scan_cnt == '0) ? ST_TERM : ST_STREAM;
        end else begin
          scan_cnt_next = scan_cnt + 1'b1;
          scan_ptr_next = ptr_next(scan_ptr);
        end
      end
      ST_STREAM: begin
        if (!dv) begin
          mem_re    = 1'b1;
          mem_raddr = sp;
          dv_next   = 1'b1;
        end else if (push_ready) begin
          push                       = 1'b1;
          push_data.char_out         = mem_rdata;
          push_data.char_valid       = 1'b1;
          push_data.free_space       = free_of(wp, rp);
          push_data.pending_messages = FIELD_W'(count);
          if (left == PTR_W'(1)) begin
            state_next = ST_TERM;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_next(sp);
            sp_next   = ptr_next(sp);
            left_next = left - 1'b1;
          end
        end
      end
      ST_TERM: begin
        if (push_ready) begin
          push                       = 1'b1;
          push_data.char_out         = CH_SEMI;
          push_data.char_valid       = 1'b1;
          push_data.last             = 1'b1;
          push_data.free_space       = free_of(wp, rp);
          push_data.pending_messages = FIELD_W'(count);
          state_next                 = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      wp    <= PTR_W'(1);
      rp    <= PTR_W'(1);
      count <= '0;
      dv    <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      rp    <= rp_next;
      count <= count_next;
      dv    <= dv_next;
    end
  end

  always_ff @(posedge clk) begin
    sp       <= sp_next;
    scan_ptr <= scan_ptr_next;
    scan_cnt <= scan_cnt_next;
    left     <= left_next;
  end

  dmrb_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dmrb_oreg u_oreg (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data)
  );

  assign m_axis_tdata = {2'b00, out_data.pending_messages, out_data.free_space,
                         out_data.char_out};
  assign m_axis_tuser = out_data.char_valid;
  assign m_axis_tlast = out_data.last;

endmodule

@@ rtl/core/dmrb_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrb_store
// Byte ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmrb_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [dmrb_pkg::PTR_W-1:0]  waddr,
  input  logic [dmrb_pkg::CHAR_W-1:0] wdata,
  input  logic                        re,
  input  logic [dmrb_pkg::PTR_W-1:0]  raddr,
  output logic [dmrb_pkg::CHAR_W-1:0] rdata
);
  import dmrb_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dmrb_oreg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmrb_oreg
// Two-entry result buffer that decouples the sequencer from the consumer.
// ----------------------------------------------------------------------------
module dmrb_oreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dmrb_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dmrb_pkg::result_t out_data
);
  import dmrb_pkg::*;

  result_t    slot [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign out_valid  = (fill != 2'd0);
  assign out_data   = slot[rd_sel];
  assign do_push    = push && push_ready;
  assign do_pop     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_sel] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_sel <= ~wr_sel;
      end
      if (do_pop) begin
        rd_sel <= ~rd_sel;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delimited message ring buffer. Put and take
// requests go in on the input stream. A ring model inside the bench predicts
// every result, and each result on the output stream is compared field by
// field. Both sides idle at random, and the consumer stalls long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import dmrb_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 240;
  localparam int SETTLE       = 150;   // Longer than one full 63-byte take.
  localparam int MAX_PRINTS   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Ring model of the block, updated once per accepted request.
  logic [7:0]       ring_bytes   [DEPTH];
  bit               ring_written [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] msg_count;
  result_t          expected_results [$];

  int   error_count  = 0;
  int   items_sent   = 0;
  logic no_idle      = 1'b0;
  logic stall_output = 1'b0;
  event hold_output;

  delimited_message_ring_buffer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % DEPTH);
  endfunction

  // A clear plants ';' in slot 0 and restarts both pointers at slot 1.
  function automatic void clear_ring_model();
    ring_bytes[0]   = CH_SEMI;
    ring_written[0] = 1'b1;
    wr_ptr          = PTR_W'(1 % DEPTH);
    rd_ptr          = PTR_W'(1 % DEPTH);
    msg_count       = '0;
  endfunction

  // True when a take now would only read slots that hold written bytes.
  function automatic bit take_reads_written();
    logic [PTR_W-1:0] p;
    p = rd_ptr;
    if (msg_count == 0) return 1'b1;
    for (int n = 0; n < DEPTH - 1; n++) begin
      if (!ring_written[p]) return 1'b0;
      if (ring_bytes[p] == CH_SEMI) return 1'b1;
      p = ring_advance(p);
    end
    return 1'b1;
  endfunction

  function automatic void predict_ring_step(input op_t op, input logic [7:0] ch);
    result_t step_res [$];
    result_t r;
    int      ring_span;
    r = '0;
    if (op == OP_PUT) begin
      if (ch == CH_BANG) begin
        clear_ring_model();
      end else if (ch >= CH_PRINT_LOW && ch < CH_PRINT_END) begin
        ring_bytes[wr_ptr]   = ch;
        ring_written[wr_ptr] = 1'b1;
        wr_ptr               = ring_advance(wr_ptr);
        if (ch == CH_SEMI && msg_count < DEPTH) msg_count++;
      end
      r.last = 1'b1;
      step_res.push_back(r);
    end else if (msg_count == 0) begin
      r.last = 1'b1;
      step_res.push_back(r);
    end else begin
      // Stream up to DEPTH-1 bytes; a message with no ';' in reach is cut
      // there and the read pointer skips one slot as if over a delimiter.
      r.char_valid = 1'b1;
      while (step_res.size() < DEPTH - 1 && ring_bytes[rd_ptr] != CH_SEMI) begin
        r.char_out = ring_bytes[rd_ptr];
        step_res.push_back(r);
        rd_ptr = ring_advance(rd_ptr);
      end
      rd_ptr     = ring_advance(rd_ptr);
      msg_count--;
      r.char_out = CH_SEMI;
      r.last     = 1'b1;
      step_res.push_back(r);
    end
    // Free space and pending count reflect the state after the whole step.
    ring_span = (int'(wr_ptr) + DEPTH - int'(rd_ptr)) % DEPTH;
    foreach (step_res[i]) begin
      step_res[i].free_space       = FIELD_W'(DEPTH - ring_span);
      step_res[i].pending_messages = FIELD_W'(msg_count);
      expected_results.push_back(step_res[i]);
    end
  endfunction

  // Printing stops after a while so that a broken block cannot flood the log.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    end
    error_count++;
  endtask

  // Offers one request and returns in the step it is accepted. A take that
  // would read a slot never written is dropped without being offered.
  task automatic send_item(input op_t op, input logic [7:0] ch);
    if (op == OP_TAKE && !take_reads_written()) return;
    while (!no_idle && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ch;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_ring_step(op, ch);
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] ch);
    send_item(OP_PUT, ch);
  endtask

  task automatic take_message();
    send_item(OP_TAKE, 8'($urandom_range(0, 255)));
  endtask

  // Lowers valid for one cycle so the last request is not taken twice.
  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(int'(CH_PRINT_LOW), int'(CH_PRINT_END) - 1));
    end while (b == CH_SEMI);
    return b;
  endfunction

  task automatic test_empty_and_ignored();
    send_item(OP_TAKE, 8'hFF);
    put_byte(8'h00);
    put_byte(8'h1F);
    put_byte(CH_PRINT_END);
    put_byte(8'h80);
    put_byte(8'hFF);
    send_item(OP_TAKE, 8'h00);
    drop_valid();
  endtask

  task automatic test_message_basics();
    // Lowest and highest stored byte, then an empty message.
    put_byte(CH_PRINT_LOW);
    put_byte(8'd126);
    put_byte(CH_SEMI);
    put_byte(CH_SEMI);
    take_message();
    take_message();
    take_message();
    // A clear drops the stored message and the pending count.
    put_byte(8'h61);
    put_byte(CH_SEMI);
    put_byte(CH_BANG);
    take_message();
    put_byte(8'h7A);
    put_byte(CH_SEMI);
    send_item(OP_TAKE, 8'h55);
    drop_valid();
  endtask

  // Sixty-three bytes with no delimiter fill the ring from slot 1; the ';'
  // lands in slot 0, so the take gives the longest stream the block allows.
  task automatic test_missing_delimiter();
    put_byte(CH_BANG);
    for (int i = 0; i < DEPTH - 1; i++) put_byte(8'(65 + (i % 26)));
    put_byte(CH_SEMI);
    take_message();
    put_byte(8'h41);
    put_byte(CH_SEMI);
    take_message();
    drop_valid();
  endtask

  // The consumer stops while many delimiters go in: the result buffer fills,
  // input stalls, the ring wraps over old bytes and the count saturates.
  task automatic test_full_stall();
    put_byte(CH_BANG);
    -> hold_output;
    for (int i = 0; i < DEPTH + 6; i++) put_byte(CH_SEMI);
    for (int i = 0; i < 4; i++) take_message();
    drop_valid();
  endtask

  task automatic test_back_to_back();
    no_idle <= 1'b1;
    put_byte(CH_BANG);
    for (int m = 0; m < 12; m++) begin
      for (int i = 0; i < $urandom_range(0, 6); i++) put_byte(rand_text_byte());
      put_byte(CH_SEMI);
      if (m % 2 == 1) begin
        take_message();
        take_message();
      end
    end
    take_message();
    drop_valid();
    no_idle <= 1'b0;
  endtask

  // Mostly whole messages and takes, with some noise bytes and clears.
  task automatic test_random_traffic();
    int start;
    int pick;
    int len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH - 2)
                                            : $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            put_byte(8'($urandom_range(0, 255)));
          end else begin
            put_byte(rand_text_byte());
          end
        end
        put_byte(CH_SEMI);
      end else if (pick < 85) begin
        take_message();
      end else if (pick < 97) begin
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_byte(CH_BANG);
      end
    end
    drop_valid();
  endtask

  always @(posedge clk) begin
    if (rst || stall_output) begin
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 38);
    end
  end

  initial begin
    forever begin
      @(hold_output);
      stall_output <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      stall_output <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, tdata", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[7:0] !== want.char_out)
          report_mismatch("char_out", 32'(m_axis_tdata[7:0]), 32'(want.char_out));
        if (m_axis_tuser !== want.char_valid)
          report_mismatch("char_valid", 32'(m_axis_tuser), 32'(want.char_valid));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tdata[14:8] !== want.free_space)
          report_mismatch("free_space", 32'(m_axis_tdata[14:8]), 32'(want.free_space));
        if (m_axis_tdata[21:15] !== want.pending_messages)
          report_mismatch("pending_messages", 32'(m_axis_tdata[21:15]),
                          32'(want.pending_messages));
        if (m_axis_tdata[23:22] !== 2'b00)
          report_mismatch("tdata padding", 32'(m_axis_tdata[23:22]), 32'd0);
      end
    end
  end

  initial begin
    clear_ring_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_ignored();
    test_message_basics();
    test_missing_delimiter();
    test_full_stall();
    test_back_to_back();
    test_random_traffic();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dmrb_pkg.sv
rtl/core/dmrb_store.sv
rtl/core/dmrb_oreg.sv
rtl/core/delimited_message_ring_buffer.sv
tb/sv/tb_top.sv
